FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL. Both take a label, an antecedent,
// a consequent and a message, and are sampled on the rising clock edge
// outside of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define UF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define UF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/uf_pkg.sv
package uf_pkg;

   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int OP_W   = 2;
   localparam int STS_W  = 2;
   localparam int RANK_W = 4;

   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_MAKE  = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNION = 2'd3;

   localparam logic [STS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STS_W-1:0] ST_DEAD = 2'd1;
   localparam logic [STS_W-1:0] ST_FULL = 2'd2;

   // Source of the node register's next value, which is also the table read address.
   typedef enum logic [2:0] {
      NODE_HOLD,
      NODE_A,
      NODE_B,
      NODE_PAR,
      NODE_ZERO,
      NODE_INC
   } node_src_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_SWEEP,
      WR_COMPRESS,
      WR_NEW,
      WR_LINK,
      WR_BUMP
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_INIT
   } count_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_NEW,
      RES_RA,
      RES_UPPER
   } res_sel_type;

   typedef struct packed {
      logic             capture;
      node_src_type     node_src;
      wr_sel_type       wr_sel;
      count_op_type     count_op;
      logic             root_latch;
      logic             side_b;
      logic             res_load;
      res_sel_type      res_sel;
      logic [STS_W-1:0] status;
      logic             rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            par_self;
      logic            comp_stop;
      logic            sweep_last;
      logic            table_full;
      logic            a_dead;
      logic            b_dead;
      logic            roots_same;
      logic            rank_tie;
   } flags_type;

endpackage

FILE: design/uf_datapath.sv
module uf_datapath #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  uf_pkg::cmd_type           cmd,
   output uf_pkg::flags_type         flags,
   input  logic [uf_pkg::OP_W-1:0]   req_opcode,
   input  logic [uf_pkg::IDX_W-1:0]  req_first,
   input  logic [uf_pkg::IDX_W-1:0]  req_second,
   input  logic                      csr_we,
   input  logic [uf_pkg::CNT_W-1:0]  csr_wdata,
   output logic [uf_pkg::IDX_W-1:0]  rsp_result,
   output logic [uf_pkg::STS_W-1:0]  rsp_status,
   output logic [uf_pkg::CNT_W-1:0]  rsp_live
);
   import uf_pkg::*;

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W + 1;
   localparam int MW = RANK_W + IW;

   // Each entry holds the rank above the parent index.
   logic [MW-1:0] mem [TABLE_SIZE];
   logic [MW-1:0] rd_ff;

   logic [OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]  a_ff, b_ff;
   logic [IW-1:0]     node_ff, node_in;
   logic [IW-1:0]     root_ff, ra_ff, rb_ff;
   logic [RANK_W-1:0] rank_a_ff, rank_b_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]  sets_ff;
   logic [IW-1:0]     res_ff, res_in;
   logic [STS_W-1:0]  sts_ff;
   logic [IDX_W-1:0]  out_res_ff;
   logic [STS_W-1:0]  out_sts_ff;
   logic [CNT_W-1:0]  out_cnt_ff;

   logic [XW-1:0]     a_x, b_x, count_x, sets_x, sat_x, res_x;
   logic [IW-1:0]     a_addr, b_addr, rd_par, upper, new_idx;
   logic [RANK_W-1:0] rd_rank;
   logic              a_below;
   logic              we;
   logic [IW-1:0]     waddr;
   logic [MW-1:0]     wdata;

   always_comb begin
      a_x     = XW'(a_ff);
      b_x     = XW'(b_ff);
      count_x = XW'(count_ff);
      sets_x  = XW'(sets_ff);
      sat_x   = (sets_x > XW'(TABLE_SIZE)) ? XW'(TABLE_SIZE) : sets_x;
      res_x   = XW'(res_ff);
      a_addr  = a_x[IW-1:0];
      b_addr  = b_x[IW-1:0];
      new_idx = count_ff[IW-1:0];
      rd_par  = rd_ff[IW-1:0];
      rd_rank = rd_ff[MW-1:IW];
      a_below = rank_a_ff < rank_b_ff;
      upper   = a_below ? rb_ff : ra_ff;
   end

   always_comb begin
      case (cmd.node_src)
         NODE_A:    node_in = a_addr;
         NODE_B:    node_in = b_addr;
         NODE_PAR:  node_in = rd_par;
         NODE_ZERO: node_in = '0;
         NODE_INC:  node_in = node_ff + IW'(1);
         default:   node_in = node_ff;
      endcase
   end

   always_comb begin
      we    = 1'b1;
      waddr = node_ff;
      wdata = {RANK_W'(0), node_ff};
      case (cmd.wr_sel)
         WR_SWEEP: begin
            waddr = node_ff;
            wdata = {RANK_W'(0), node_ff};
         end
         WR_COMPRESS: begin
            waddr = node_ff;
            wdata = {rd_rank, root_ff};
         end
         WR_NEW: begin
            waddr = new_idx;
            wdata = {RANK_W'(0), new_idx};
         end
         WR_LINK: begin
            // The lower-ranked root goes under the other and keeps its rank.
            waddr = a_below ? ra_ff : rb_ff;
            wdata = a_below ? {rank_a_ff, rb_ff} : {rank_b_ff, ra_ff};
         end
         WR_BUMP: begin
            waddr = ra_ff;
            wdata = {rank_a_ff + RANK_W'(1), ra_ff};
         end
         default: we = 1'b0;
      endcase
   end

   always_comb begin
      case (cmd.count_op)
         CNT_INC:  count_in = count_ff + CW'(1);
         CNT_INIT: count_in = sat_x[CW-1:0];
         default:  count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.res_sel)
         RES_NEW:   res_in = new_idx;
         RES_RA:    res_in = ra_ff;
         RES_UPPER: res_in = upper;
         default:   res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[node_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff  <= '0;
         count_ff <= '0;
         sets_ff  <= '0;
      end else begin
         node_ff  <= node_in;
         count_ff <= count_in;
         if (csr_we) begin
            sets_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_opcode;
         a_ff  <= req_first;
         b_ff  <= req_second;
      end
      if (cmd.root_latch) begin
         root_ff <= node_ff;
         if (cmd.side_b) begin
            rb_ff     <= node_ff;
            rank_b_ff <= rd_rank;
         end else begin
            ra_ff     <= node_ff;
            rank_a_ff <= rd_rank;
         end
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
         sts_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         out_res_ff <= res_x[IDX_W-1:0];
         out_sts_ff <= sts_ff;
         out_cnt_ff <= count_x[CNT_W-1:0];
      end
   end

   always_comb begin
      flags.opcode     = op_ff;
      flags.par_self   = rd_par == node_ff;
      flags.comp_stop  = (rd_par == root_ff) || (node_ff == root_ff);
      flags.sweep_last = node_ff == IW'(TABLE_SIZE - 1);
      flags.table_full = count_ff == CW'(TABLE_SIZE);
      flags.a_dead     = a_x >= count_x;
      flags.b_dead     = b_x >= count_x;
      flags.roots_same = ra_ff == rb_ff;
      flags.rank_tie   = (rank_a_ff == rank_b_ff) && (rank_a_ff != RANK_MAX);
   end

   assign rsp_result = out_res_ff;
   assign rsp_status = out_sts_ff;
   assign rsp_live   = out_cnt_ff;

endmodule

FILE: design/uf_ctrl.sv
module uf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  uf_pkg::flags_type flags,
   output uf_pkg::cmd_type   cmd
);
   import uf_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CHECK     = 4'd1;
   localparam logic [3:0] S_WALK      = 4'd2;
   localparam logic [3:0] S_COMP      = 4'd3;
   localparam logic [3:0] S_LINK      = 4'd4;
   localparam logic [3:0] S_BUMP      = 4'd5;
   localparam logic [3:0] S_SWEEP_RST = 4'd6;
   localparam logic [3:0] S_SWEEP_CLR = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       side_ff, side_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      side_in    = side_ff;
      cmd        = '0;
      cmd.side_b = side_ff;
      req_tready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            case (flags.opcode)
               OP_CLEAR: begin
                  cmd.node_src = NODE_ZERO;
                  state_in     = S_SWEEP_CLR;
               end
               OP_MAKE: begin
                  cmd.res_load = 1'b1;
                  if (flags.table_full) begin
                     cmd.res_sel = RES_ZERO;
                     cmd.status  = ST_FULL;
                  end else begin
                     cmd.wr_sel   = WR_NEW;
                     cmd.count_op = CNT_INC;
                     cmd.res_sel  = RES_NEW;
                     cmd.status   = ST_OK;
                  end
                  state_in = S_DONE;
               end
               OP_FIND, OP_UNION: begin
                  if (flags.a_dead || (flags.opcode == OP_UNION && flags.b_dead)) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RES_ZERO;
                     cmd.status   = ST_DEAD;
                     state_in     = S_DONE;
                  end else begin
                     cmd.node_src = NODE_A;
                     side_in      = 1'b0;
                     state_in     = S_WALK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_WALK: begin
            if (flags.par_self) begin
               // Root found; reread the start node to begin compressing.
               cmd.root_latch = 1'b1;
               cmd.node_src   = side_ff ? NODE_B : NODE_A;
               state_in       = S_COMP;
            end else begin
               cmd.node_src = NODE_PAR;
            end
         end
         S_COMP: begin
            if (flags.comp_stop) begin
               if (side_ff) begin
                  state_in = S_LINK;
               end else if (flags.opcode == OP_FIND) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_RA;
                  cmd.status   = ST_OK;
                  state_in     = S_DONE;
               end else begin
                  side_in      = 1'b1;
                  cmd.node_src = NODE_B;
                  state_in     = S_WALK;
               end
            end else begin
               cmd.wr_sel   = WR_COMPRESS;
               cmd.node_src = NODE_PAR;
            end
         end
         S_LINK: begin
            cmd.res_load = 1'b1;
            cmd.status   = ST_OK;
            if (flags.roots_same) begin
               cmd.res_sel = RES_RA;
               state_in    = S_DONE;
            end else begin
               cmd.wr_sel  = WR_LINK;
               cmd.res_sel = RES_UPPER;
               state_in    = flags.rank_tie ? S_BUMP : S_DONE;
            end
         end
         S_BUMP: begin
            cmd.wr_sel = WR_BUMP;
            state_in   = S_DONE;
         end
         S_SWEEP_RST, S_SWEEP_CLR: begin
            cmd.wr_sel   = WR_SWEEP;
            cmd.node_src = NODE_INC;
            if (flags.sweep_last) begin
               if (state_ff == S_SWEEP_CLR) begin
                  cmd.count_op = CNT_INIT;
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_ZERO;
                  cmd.status   = ST_OK;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP_RST;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: design/union_find_rank_path_compression.sv
// Disjoint-set table with union by rank and path compression.
// The request stream carries one operation per transaction: clear, append of
// a new element, find or union. The response stream returns exactly one
// transaction per request, in order, with the resulting index, a status code
// and the live element count after the operation.
// Requests are handled one at a time. An append and rejected operations go
// from the check state straight to the done state. A find walks from its node
// of depth d up to its root and back down to compress the path. A union walks
// from both nodes, then links the two roots, with a rank bump when two
// distinct roots tie in a rank below RANK_MAX. Ranking keeps d near log2 of
// the table size. Every step is one registered read of the table memory, with
// at most one write beside it. A clear rewrites the whole table, one entry per
// cycle, before it answers. After reset the same pass runs with req_tready
// low; csr writes are taken at any time.
// The finished result sits in an output register, so the next request is
// accepted while it waits; a stalled receiver only holds up the following
// response.
`include "assert_macros.svh"

module union_find_rank_path_compression #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // csr_wdata: initial_sets[10:0]
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata: first_index[9:0], second_index[19:10], zero fill [23:20]
   input  logic [23:0] req_tdata,
   // req_tuser: opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: result_index[9:0], live_count[20:10], zero fill [23:21]
   output logic [23:0] rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]  rsp_tuser
);
   import uf_pkg::*;

   cmd_type           cmd;
   flags_type         flags;
   logic [IDX_W-1:0]  rsp_result;
   logic [CNT_W-1:0]  rsp_live;

   uf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   uf_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_opcode (req_tuser),
      .req_first  (req_tdata[9:0]),
      .req_second (req_tdata[19:10]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_result (rsp_result),
      .rsp_status (rsp_tuser),
      .rsp_live   (rsp_live)
   );

   assign rsp_tdata = {3'b000, rsp_live, rsp_result};

   // One request at a time: nothing is taken right after an acceptance.
   `UF_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready,
      "request accepted while the previous one is still in progress")

   // A new result must never overwrite one the receiver has not taken.
   `UF_ASSERT_SAME(a_no_overwrite, cmd.rsp_load, !rsp_tvalid || rsp_tready,
      "response register reloaded while holding an untaken transaction")

   // The table is only written while an operation or sweep is running.
   `UF_ASSERT_SAME(a_idle_no_write, req_tready, cmd.wr_sel == WR_NONE,
      "table written while waiting for a request")

endmodule
